// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// shared types and constants for the ring buffer deque core
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 5;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                       cmd;
        logic signed [VALUE_W-1:0]  push_value;
    } request_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  front_value;
        logic signed [VALUE_W-1:0]  back_value;
        logic [ENTRY_COUNT_W-1:0]   entry_count;
        logic [1:0]                 status;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_UPDATE = 2'd1,
        ST_READ   = 2'd2,
        ST_RESULT = 2'd3
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic read;
        logic publish;
    } ctrl_t;

endpackage

// ===== rtl/ring_buffer_deque_core.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque_core
// double-ended queue of signed 32-bit values in a circular store
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------
//   command  | start / busy     | request: cmd, push_value
//   result   | done (one cycle) | result: front_value, back_value,
//            |                  |         entry_count, status
//
// one item at a time, in order: capture, pointer and store update, registered
// read of both ends from the two-read-port store, result cycle
// done is high for exactly one cycle per item; the receiver cannot stall
// busy is high from the cycle after acceptance through the done cycle
// reset clears slots and count; store contents are undefined until written
// ----------------------------------------------------------------------------
module ring_buffer_deque_core
    import rbd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    ctrl_t ctrl;

    rbd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    rbd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .request (request),
        .result  (result)
    );

    assign done = ctrl.publish;

endmodule

// ===== rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// sequencer: capture, update pointers and store, read ends, publish result
// ----------------------------------------------------------------------------
module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ctrl.update = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                ctrl.read  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                ctrl.publish = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rbd_datapath.sv =====
// ----------------------------------------------------------------------------
// rbd_datapath
// entry store, front and back slots, entry count and result registers
// ----------------------------------------------------------------------------
module rbd_datapath
    import rbd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  ctrl_t    ctrl,
    input  request_t request,
    output result_t  result
);

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEPTH - 1);

    logic [VALUE_W-1:0] mem [DEPTH];

    request_t           req_reg;
    logic [SLOT_W-1:0]  front_slot_reg;
    logic [SLOT_W-1:0]  back_slot_reg;
    logic [CNT_W-1:0]   count_reg;
    status_t            status_reg;
    logic [VALUE_W-1:0] rd_front_reg;
    logic [VALUE_W-1:0] rd_back_reg;

    logic [SLOT_W-1:0]  front_up;
    logic [SLOT_W-1:0]  front_down;
    logic [SLOT_W-1:0]  back_up;
    logic [SLOT_W-1:0]  back_down;
    logic               full;
    logic               empty;
    logic               is_push;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;

    assign front_up   = (front_slot_reg == SLOT_LAST) ? '0 : front_slot_reg + 1'b1;
    assign front_down = (front_slot_reg == '0) ? SLOT_LAST : front_slot_reg - 1'b1;
    assign back_up    = (back_slot_reg == SLOT_LAST) ? '0 : back_slot_reg + 1'b1;
    assign back_down  = (back_slot_reg == '0) ? SLOT_LAST : back_slot_reg - 1'b1;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign is_push = (req_reg.cmd == CMD_PUSH_FRONT) || (req_reg.cmd == CMD_PUSH_BACK);
    assign wr_en   = ctrl.update && is_push && !full;
    assign wr_addr = (req_reg.cmd == CMD_PUSH_FRONT) ? front_slot_reg : back_down;

    // store and payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            req_reg <= request;
        end
        if (wr_en)
        begin
            mem[wr_addr] <= req_reg.push_value;
        end
        if (ctrl.read)
        begin
            rd_front_reg <= mem[front_down];
            rd_back_reg  <= mem[back_slot_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_slot_reg <= '0;
            back_slot_reg  <= '0;
            count_reg      <= '0;
            status_reg     <= STATUS_OK;
        end
        else if (ctrl.update)
        begin
            status_reg <= STATUS_OK;
            case (req_reg.cmd)
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_reg <= STATUS_FULL;
                    end
                    else
                    begin
                        front_slot_reg <= front_up;
                        count_reg      <= count_reg + 1'b1;
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_reg <= STATUS_FULL;
                    end
                    else
                    begin
                        back_slot_reg <= back_down;
                        count_reg     <= count_reg + 1'b1;
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_reg <= STATUS_EMPTY;
                    end
                    else
                    begin
                        front_slot_reg <= front_down;
                        count_reg      <= count_reg - 1'b1;
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_reg <= STATUS_EMPTY;
                    end
                    else
                    begin
                        back_slot_reg <= back_up;
                        count_reg     <= count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_reg <= STATUS_OK;
                end
            endcase
        end
    end

    // empty queue reads zero at both ends
    always_comb
    begin
        result.front_value = empty ? '0 : rd_front_reg;
        result.back_value  = empty ? '0 : rd_back_reg;
        result.entry_count = ENTRY_COUNT_W'(count_reg);
        result.status      = status_reg;
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks ring_buffer_deque_core against a behavioral deque: directed pushes
// and pops through empty, full and slot wrap, then random phases biased
// toward filling, balance or draining, with random idle cycles on the command side
// ----------------------------------------------------------------------------
module testbench;
    import rbd_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEFAULT;

    logic     clk;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    request_t pending_items [$];
    result_t  expected_results [$];
    int       issued_count = 0;
    int       taken_count  = 0;
    int       error_count  = 0;

    logic signed [VALUE_W-1:0] deque_store [QUEUE_DEPTH];
    int deque_front_slot = 0;
    int deque_back_slot  = 0;
    int deque_count      = 0;

    ring_buffer_deque_core uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic result_t apply_deque_command(input request_t r);
        result_t res;
        status_t st;
        st = STATUS_OK;
        if (r.cmd == CMD_PUSH_FRONT || r.cmd == CMD_PUSH_BACK)
        begin
            if (deque_count >= QUEUE_DEPTH)
                st = STATUS_FULL;
            else if (r.cmd == CMD_PUSH_FRONT)
            begin
                deque_store[deque_front_slot] = r.push_value;
                deque_front_slot = (deque_front_slot + 1) % QUEUE_DEPTH;
                deque_count++;
            end
            else
            begin
                deque_back_slot = (deque_back_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                deque_store[deque_back_slot] = r.push_value;
                deque_count++;
            end
        end
        else
        begin
            if (deque_count == 0)
                st = STATUS_EMPTY;
            else if (r.cmd == CMD_POP_FRONT)
            begin
                deque_front_slot = (deque_front_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                deque_count--;
            end
            else
            begin
                deque_back_slot = (deque_back_slot + 1) % QUEUE_DEPTH;
                deque_count--;
            end
        end
        res = '0;
        if (deque_count != 0)
        begin
            res.front_value = deque_store[(deque_front_slot + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
            res.back_value  = deque_store[deque_back_slot];
        end
        res.entry_count = deque_count[ENTRY_COUNT_W-1:0];
        res.status      = st;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic add_item(input cmd_t c, input logic signed [VALUE_W-1:0] v);
        request_t r;
        r.cmd        = c;
        r.push_value = v;
        pending_items.push_back(r);
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh00000000;
            3: return 32'shffffffff;
            default: return $urandom;
        endcase
    endfunction

    // command driver
    always @(negedge clk)
    begin
        if (rst_n && (!start || taken_count == issued_count))
        begin
            if (pending_items.size() != 0 &&
                !($urandom_range(99) < 27 && !(issued_count >= 400 && issued_count < 600)))
            begin
                request      <= pending_items.pop_front();
                start        <= 1'b1;
                issued_count <= issued_count + 1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // result check and prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", 32'(result.entry_count), 32'd0);
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    if (result.front_value !== want.front_value)
                        report_mismatch("front_value", result.front_value, want.front_value);
                    if (result.back_value !== want.back_value)
                        report_mismatch("back_value", result.back_value, want.back_value);
                    if (result.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(result.entry_count),
                                        32'(want.entry_count));
                    if (result.status !== want.status)
                        report_mismatch("status", 32'(result.status), 32'(want.status));
                end
            end
            if (start && !busy)
            begin
                expected_results.push_back(apply_deque_command(request));
                taken_count <= taken_count + 1;
            end
        end
    end

    initial
    begin
        int push_pct;
        cmd_t c;

        // empty pops, back push wrapping below slot 0, extremes, fill, full, a pop at each end
        add_item(CMD_POP_FRONT, 32'sh12345678);
        add_item(CMD_POP_BACK, 32'shedcba987);
        add_item(CMD_PUSH_BACK, 32'sh80000000);
        add_item(CMD_PUSH_FRONT, 32'sh7fffffff);
        for (int i = 0; i < 14; i++)
            add_item((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                     (i % 3 == 0) ? 32'shffffffff : (i % 3 == 1) ? 32'sh0 : $urandom);
        add_item(CMD_PUSH_FRONT, 32'sh55555555);
        add_item(CMD_PUSH_BACK, 32'shaaaaaaaa);
        add_item(CMD_POP_FRONT, 32'sh0);
        add_item(CMD_POP_BACK, 32'shffffffff);

        // random phases biased toward fill, balance or drain
        for (int b = 0; b < 25; b++)
        begin
            case ($urandom_range(2))
                0: push_pct = 15;
                1: push_pct = 50;
                default: push_pct = 85;
            endcase
            for (int i = 0; i < 40; i++)
            begin
                if ($urandom_range(99) < push_pct)
                    c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                    c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
                add_item(c, random_value());
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || taken_count != issued_count ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rbd_pkg.sv
rtl/rbd_ctrl.sv
rtl/rbd_datapath.sv
rtl/ring_buffer_deque_core.sv
bench/testbench.sv
